// ===== src/stl_pkg.sv =====
// Shared types, codes and character constants for the source text lexer.
// No dependencies; imported by every module of the block.
package stl_pkg;

    // Output field widths, fixed by the token transaction format
    localparam int LINE_W   = 16;
    localparam int COLUMN_W = 16;
    localparam int OFFSET_W = 32;

    // Defaults for the internal position counters
    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // Event kinds
    localparam logic [1:0] KIND_WORD  = 2'd0;
    localparam logic [1:0] KIND_MARK  = 2'd1;
    localparam logic [1:0] KIND_QUOTE = 2'd2;
    localparam logic [1:0] KIND_CLOSE = 2'd3;

    // Characters with a special role
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          event_kind;
        logic [7:0]          char_out;
        logic                token_first;
        logic                token_final;
        logic [LINE_W-1:0]   start_line;
        logic [COLUMN_W-1:0] start_column;
        logic [OFFSET_W-1:0] start_offset;
        logic                run_last;
    } out_item_t;

    // Results of one lexer step: up to two events
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } step_t;

    // Newline and punctuation: each ends a word and forms its own token
    function automatic logic is_mark(input logic [7:0] c);
        logic r;
        case (c) inside
            CH_NL, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E,
            8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
            8'h2D, 8'h2B, 8'h3D, 8'h7C, CH_BSLASH, 8'h3A, 8'h3B, 8'h2C,
            8'h2E, 8'h3F, 8'h2F: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/source_text_lexer.sv =====
// Top level of the streaming source text lexer.
// Depends on stl_pkg, stl_core and stl_out_buf.

// Takes one byte of source text per text transaction and returns token event
// transactions. Spaces and tabs end a word; newline and punctuation end a word
// and form one-character tokens; single or double quotes open a quoted token
// that runs to the matching unescaped quote. Each event carries the line,
// column and byte offset of its token's first character, saturating. The
// block sustains one byte per cycle unless the receiver stalls or a byte
// yields two events: a byte sits in the input register while the step logic
// works it out, and its events land in the result register. A byte that both
// closes a word and opens a new token yields two events, which hold the input
// register while the second event drains. A byte's first event passes the input
// register, then the result register. End of text resets all positions so the next byte starts a new text.
module source_text_lexer #(
    parameter int LINE_BITS   = stl_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = stl_pkg::COLUMN_BITS_DEF,
    parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  stl_pkg::in_item_t  text_item,
    output logic               token_valid,
    input  logic               token_ready,
    output stl_pkg::out_item_t token_item
);
    import stl_pkg::*;

    // Input register
    logic     in_valid_reg;
    in_item_t in_item_reg;

    step_t    result;
    logic     can_load;
    logic     step;

    // Byte in the input register is worked once the result register has room
    assign step       = in_valid_reg && can_load;
    assign text_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (text_ready)
            in_valid_reg <= text_valid;
    end

    always_ff @(posedge clk)
    begin
        if (text_ready && text_valid)
            in_item_reg <= text_item;
    end

    stl_core #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_item_reg),
        .step   (step),
        .result (result)
    );

    stl_out_buf u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .result      (result),
        .load        (step),
        .can_load    (can_load),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_item  (token_item)
    );

endmodule

// ===== src/stl_core.sv =====
// Lexer step logic and scan state (mode, quote, escape, positions).
// Depends on stl_pkg.
module stl_core #(
    parameter int LINE_BITS   = stl_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = stl_pkg::COLUMN_BITS_DEF,
    parameter int OFFSET_BITS = stl_pkg::OFFSET_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  stl_pkg::in_item_t item,
    input  logic             step,
    output stl_pkg::step_t   result
);
    import stl_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_WORD  = 3'b010,
        MODE_QUOTE = 3'b100
    } mode_t;

    localparam int LX = (LINE_BITS > LINE_W) ? LINE_BITS : LINE_W;
    localparam int CX = (COLUMN_BITS > COLUMN_W) ? COLUMN_BITS : COLUMN_W;
    localparam int OX = (OFFSET_BITS > OFFSET_W) ? OFFSET_BITS : OFFSET_W;

    mode_t                  mode_reg, mode_next;
    logic [7:0]             quote_reg, quote_next;
    logic                   esc_reg, esc_next;
    logic [LINE_BITS-1:0]   cur_line_reg, cur_line_next, tok_line_reg, tok_line_next;
    logic [COLUMN_BITS-1:0] cur_col_reg, cur_col_next, tok_col_reg, tok_col_next;
    logic [OFFSET_BITS-1:0] cur_off_reg, cur_off_next, tok_off_reg, tok_off_next;

    logic [LX-1:0] cur_line_x, tok_line_x;
    logic [CX-1:0] cur_col_x, tok_col_x;
    logic [OX-1:0] cur_off_x, tok_off_x;
    logic [LINE_W-1:0]   cur_line_f, tok_line_f;
    logic [COLUMN_W-1:0] cur_col_f, tok_col_f;
    logic [OFFSET_W-1:0] cur_off_f, tok_off_f;

    logic [7:0] c;
    logic       blank, quote, mark, done, fin;
    logic       cont_valid, new_valid;
    out_item_t  cont_ev, new_ev;

    // Saturate positions into the output field widths
    assign cur_line_x = LX'(cur_line_reg);
    assign tok_line_x = LX'(tok_line_reg);
    assign cur_col_x  = CX'(cur_col_reg);
    assign tok_col_x  = CX'(tok_col_reg);
    assign cur_off_x  = OX'(cur_off_reg);
    assign tok_off_x  = OX'(tok_off_reg);

    assign cur_line_f = (cur_line_x > LX'({LINE_W{1'b1}})) ? '1 : cur_line_x[LINE_W-1:0];
    assign tok_line_f = (tok_line_x > LX'({LINE_W{1'b1}})) ? '1 : tok_line_x[LINE_W-1:0];
    assign cur_col_f  = (cur_col_x > CX'({COLUMN_W{1'b1}})) ? '1 : cur_col_x[COLUMN_W-1:0];
    assign tok_col_f  = (tok_col_x > CX'({COLUMN_W{1'b1}})) ? '1 : tok_col_x[COLUMN_W-1:0];
    assign cur_off_f  = (cur_off_x > OX'({OFFSET_W{1'b1}})) ? '1 : cur_off_x[OFFSET_W-1:0];
    assign tok_off_f  = (tok_off_x > OX'({OFFSET_W{1'b1}})) ? '1 : tok_off_x[OFFSET_W-1:0];

    assign c     = item.text_byte;
    assign blank = (c == CH_SPACE) || (c == CH_TAB);
    assign quote = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    assign mark  = is_mark(c);

    always_comb
    begin
        mode_next     = mode_reg;
        quote_next    = quote_reg;
        esc_next      = esc_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        tok_off_next  = tok_off_reg;
        done          = 1'b0;
        fin           = 1'b0;
        cont_valid    = 1'b0;
        new_valid     = 1'b0;

        // Event of the token already open: positions of its first character
        cont_ev              = '0;
        cont_ev.start_line   = tok_line_f;
        cont_ev.start_column = tok_col_f;
        cont_ev.start_offset = tok_off_f;

        new_ev              = '0;
        new_ev.char_out     = c;
        new_ev.token_first  = 1'b1;
        new_ev.start_line   = cur_line_f;
        new_ev.start_column = cur_col_f;
        new_ev.start_offset = cur_off_f;

        unique case (mode_reg)
            MODE_WORD:
            begin
                cont_valid = 1'b1;
                if (blank || mark || quote)
                begin
                    cont_ev.event_kind  = KIND_CLOSE;
                    cont_ev.token_final = 1'b1;
                    mode_next           = MODE_IDLE;
                    done                = blank;
                end
                else
                begin
                    cont_ev.event_kind = KIND_WORD;
                    cont_ev.char_out   = c;
                    done               = 1'b1;
                end
            end
            MODE_QUOTE:
            begin
                cont_valid = 1'b1;
                done       = 1'b1;
                if (esc_reg)
                    esc_next = 1'b0;
                else if (c == CH_BSLASH)
                    esc_next = 1'b1;
                else if (c == quote_reg)
                begin
                    fin        = 1'b1;
                    mode_next  = MODE_IDLE;
                    quote_next = '0;
                end
                cont_ev.event_kind  = KIND_QUOTE;
                cont_ev.char_out    = c;
                cont_ev.token_final = fin;
            end
            default: ;
        endcase

        if (!done && !blank)
        begin
            new_valid     = 1'b1;
            tok_line_next = cur_line_reg;
            tok_col_next  = cur_col_reg;
            tok_off_next  = cur_off_reg;
            if (mark)
            begin
                new_ev.event_kind  = KIND_MARK;
                new_ev.token_final = 1'b1;
            end
            else if (quote)
            begin
                new_ev.event_kind = KIND_QUOTE;
                mode_next         = MODE_QUOTE;
                quote_next        = c;
                esc_next          = 1'b0;
            end
            else
            begin
                new_ev.event_kind = KIND_WORD;
                mode_next         = MODE_WORD;
            end
        end

        cur_off_next = (cur_off_reg == '1) ? cur_off_reg : cur_off_reg + OFFSET_BITS'(1);
        if (c == CH_NL)
        begin
            cur_line_next = (cur_line_reg == '1) ? cur_line_reg : cur_line_reg + LINE_BITS'(1);
            cur_col_next  = '0;
        end
        else
        begin
            cur_line_next = cur_line_reg;
            cur_col_next  = (cur_col_reg == '1) ? cur_col_reg : cur_col_reg + COLUMN_BITS'(1);
        end

        if (cont_valid)
        begin
            result.first  = cont_ev;
            result.second = new_ev;
            result.count  = new_valid ? 2'd2 : 2'd1;
        end
        else
        begin
            result.first  = new_ev;
            result.second = '0;
            result.count  = new_valid ? 2'd1 : 2'd0;
        end

        // End of text: close any open token on its last event, then restart
        if (item.end_of_text)
        begin
            if (mode_next != MODE_IDLE)
            begin
                if (result.count == 2'd2)
                    result.second.token_final = 1'b1;
                else
                    result.first.token_final = 1'b1;
            end
            mode_next     = MODE_IDLE;
            quote_next    = '0;
            esc_next      = 1'b0;
            cur_line_next = '0;
            cur_col_next  = '0;
            cur_off_next  = '0;
            tok_line_next = '0;
            tok_col_next  = '0;
            tok_off_next  = '0;
        end

        if (result.count == 2'd2)
            result.second.run_last = 1'b1;
        else
            result.first.run_last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            quote_reg    <= '0;
            esc_reg      <= 1'b0;
            cur_line_reg <= '0;
            cur_col_reg  <= '0;
            cur_off_reg  <= '0;
            tok_line_reg <= '0;
            tok_col_reg  <= '0;
            tok_off_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            quote_reg    <= quote_next;
            esc_reg      <= esc_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            cur_off_reg  <= cur_off_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            tok_off_reg  <= tok_off_next;
        end
    end

endmodule

// ===== src/stl_out_buf.sv =====
// Result register: holds up to two events of one step and presents them in order.
// Depends on stl_pkg.
module stl_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  stl_pkg::step_t    result,
    input  logic              load,
    output logic              can_load,
    output logic              token_valid,
    input  logic              token_ready,
    output stl_pkg::out_item_t token_item
);
    import stl_pkg::*;

    logic      valid_reg, valid_next;
    logic      pend_reg, pend_next;
    out_item_t res0_reg, res0_next;
    out_item_t res1_reg, res1_next;
    logic      fire;

    assign fire        = valid_reg && token_ready;
    // Space for a fresh step once the slot drains with nothing queued behind it
    assign can_load    = !valid_reg || (fire && !pend_reg);
    assign token_valid = valid_reg;
    assign token_item  = res0_reg;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        res0_next  = res0_reg;
        res1_next  = res1_reg;
        if (fire)
        begin
            if (pend_reg)
            begin
                res0_next = res1_reg;
                pend_next = 1'b0;
            end
            else
                valid_next = 1'b0;
        end
        if (load && (result.count != 2'd0))
        begin
            valid_next = 1'b1;
            pend_next  = (result.count == 2'd2);
            res0_next  = result.first;
            res1_next  = result.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

endmodule

// ===== src/stl_checker.sv =====
// Port-level checks for source_text_lexer, attached by bind.
// Depends on stl_pkg.
module stl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               text_valid,
    input logic               text_ready,
    input stl_pkg::in_item_t  text_item,
    input logic               token_valid,
    input logic               token_ready,
    input stl_pkg::out_item_t token_item
);
    import stl_pkg::*;

    // An offered text transaction holds until taken
    a_text_hold: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid && $stable(text_item))
        else $error("text transaction dropped or changed while stalled");

    // A stalled token transaction holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_ready |=> token_valid && $stable(token_item))
        else $error("token transaction dropped or changed while stalled");

    // The second event of a byte is already buffered behind the first
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_ready && !token_item.run_last |=> token_valid)
        else $error("second event of a byte missing");

    // A word close marker carries no character and completes its token
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_item.event_kind == KIND_CLOSE) |->
        (token_item.char_out == 8'h00) && !token_item.token_first && token_item.token_final)
        else $error("malformed close marker");

    // A single-character token both opens and completes
    a_mark: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_item.event_kind == KIND_MARK) |->
        token_item.token_first && token_item.token_final && token_item.run_last)
        else $error("malformed single-character token");

endmodule

bind source_text_lexer stl_checker u_stl_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the streaming source text lexer (source_text_lexer).
// Depends on stl_pkg for the transaction structs, event kinds and character codes;
// needs nothing else but the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stl_pkg::*;

    // Cycles with no transaction on either side before the run is abandoned.
    // The slowest correct case is an 88 % receiver stall.
    localparam int STALL_LIMIT = 5000;
    localparam string PUNCT = "()[]{}<>~!@#$%^&*-+=|\\:;,.?/";
    localparam out_item_t UNTYPED = '0;

    typedef enum logic [2:0]
    {
        SCAN_IDLE  = 3'b001,
        SCAN_WORD  = 3'b010,
        SCAN_QUOTE = 3'b100
    } scan_t;

    // One row of the directed table. Where typed is set, want replaces the
    // predicted event, so the row is checked against a hand-written value.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      text_valid = 1'b0;
    logic      text_ready;
    in_item_t  text_item = '0;
    logic      token_valid;
    logic      token_ready = 1'b0;
    out_item_t token_item;

    // Scanner state as the predictor sees it
    scan_t               scan_state;
    logic [7:0]          quote_char;
    logic                esc_armed;
    logic [LINE_W-1:0]   pos_line, tok_line;
    logic [COLUMN_W-1:0] pos_column, tok_column;
    logic [OFFSET_W-1:0] pos_offset, tok_offset;

    out_item_t expected_events[$];
    in_item_t  text_buf[$];

    int send_idle_pct = 26;
    int recv_idle_pct = 88;
    int mismatches = 0;
    int bytes_sent = 0;
    int texts_sent = 0;
    int events_seen = 0;
    int idle_cycles = 0;

    // Directed walk: extremes of the byte, every event kind, word closed by a
    // blank / mark / quote, escapes and newlines inside quotes, unterminated
    // quote closed by end of text, and a fresh text after each end of text.
    stim_row_t directed_rows [26] = '{
        '{in_item_t'{8'h28, 1'b0}, 1'b1,
          out_item_t'{KIND_MARK, 8'h28, 1'b1, 1'b1, 16'd0, 16'd0, 32'd0, 1'b1}},
        '{in_item_t'{8'h61, 1'b0}, 1'b1,
          out_item_t'{KIND_WORD, 8'h61, 1'b1, 1'b0, 16'd0, 16'd1, 32'd1, 1'b1}},
        '{in_item_t'{8'hFF, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_SPACE, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_SPACE, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_TAB, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{8'h00, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_DQUOTE, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_BSLASH, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_DQUOTE, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_SQUOTE, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_NL, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_DQUOTE, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_SQUOTE, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{8'h78, 1'b1}, 1'b0, UNTYPED},
        '{in_item_t'{8'h7A, 1'b0}, 1'b1,
          out_item_t'{KIND_WORD, 8'h7A, 1'b1, 1'b0, 16'd0, 16'd0, 32'd0, 1'b1}},
        '{in_item_t'{CH_NL, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_BSLASH, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{8'h71, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{8'h72, 1'b1}, 1'b0, UNTYPED},
        '{in_item_t'{CH_NL, 1'b1}, 1'b1,
          out_item_t'{KIND_MARK, CH_NL, 1'b1, 1'b1, 16'd0, 16'd0, 32'd0, 1'b1}},
        '{in_item_t'{CH_SPACE, 1'b1}, 1'b0, UNTYPED},
        '{in_item_t'{CH_SQUOTE, 1'b1}, 1'b1,
          out_item_t'{KIND_QUOTE, CH_SQUOTE, 1'b1, 1'b1, 16'd0, 16'd0, 32'd0, 1'b1}},
        '{in_item_t'{8'h80, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_DQUOTE, 1'b0}, 1'b0, UNTYPED},
        '{in_item_t'{CH_SQUOTE, 1'b1}, 1'b0, UNTYPED}
    };

    source_text_lexer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_item   (text_item),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_item  (token_item)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Newline and the punctuation set end a word and stand alone
    function automatic logic is_punct(input logic [7:0] c);
        if (c == CH_NL)
            return 1'b1;
        for (int i = 0; i < PUNCT.len(); i++)
            if (PUNCT[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_DQUOTE || c == CH_SQUOTE
            || is_punct(c);
    endfunction

    function automatic void restart_text();
        scan_state = SCAN_IDLE;
        quote_char = 8'h00;
        esc_armed  = 1'b0;
        pos_line   = '0;
        pos_column = '0;
        pos_offset = '0;
        tok_line   = '0;
        tok_column = '0;
        tok_offset = '0;
    endfunction

    function automatic out_item_t token_event(input logic [1:0] kind, input logic [7:0] ch,
                                              input logic first, input logic fin,
                                              input logic [LINE_W-1:0] l,
                                              input logic [COLUMN_W-1:0] col,
                                              input logic [OFFSET_W-1:0] off);
        out_item_t e;
        e.event_kind   = kind;
        e.char_out     = ch;
        e.token_first  = first;
        e.token_final  = fin;
        e.start_line   = l;
        e.start_column = col;
        e.start_offset = off;
        e.run_last     = 1'b0;
        return e;
    endfunction

    // Works out the events for one accepted byte, queues them, and moves the
    // scanner state on. Counters saturate at all ones.
    function automatic void lex_byte(input in_item_t it);
        out_item_t  ev[2];
        int         n;
        logic [7:0] c;
        logic       blank, quote, punct, handled, closes;
        n       = 0;
        c       = it.text_byte;
        blank   = (c == CH_SPACE) || (c == CH_TAB);
        quote   = (c == CH_DQUOTE) || (c == CH_SQUOTE);
        punct   = is_punct(c);
        handled = 1'b0;
        closes  = 1'b0;

        if (scan_state == SCAN_WORD)
        begin
            if (blank || punct || quote)
            begin
                // close marker first; a blank ends here, anything else opens a token
                ev[n] = token_event(KIND_CLOSE, 8'h00, 1'b0, 1'b1,
                                    tok_line, tok_column, tok_offset);
                n++;
                scan_state = SCAN_IDLE;
                handled    = blank;
            end
            else
            begin
                ev[n] = token_event(KIND_WORD, c, 1'b0, 1'b0, tok_line, tok_column, tok_offset);
                n++;
                handled = 1'b1;
            end
        end
        else if (scan_state == SCAN_QUOTE)
        begin
            if (esc_armed)
                esc_armed = 1'b0;
            else if (c == CH_BSLASH)
                esc_armed = 1'b1;
            else if (c == quote_char)
            begin
                closes     = 1'b1;
                scan_state = SCAN_IDLE;
                quote_char = 8'h00;
            end
            ev[n] = token_event(KIND_QUOTE, c, 1'b0, closes, tok_line, tok_column, tok_offset);
            n++;
            handled = 1'b1;
        end

        if (!handled && !blank)
        begin
            tok_line   = pos_line;
            tok_column = pos_column;
            tok_offset = pos_offset;
            if (punct)
                ev[n] = token_event(KIND_MARK, c, 1'b1, 1'b1, pos_line, pos_column, pos_offset);
            else if (quote)
            begin
                scan_state = SCAN_QUOTE;
                quote_char = c;
                esc_armed  = 1'b0;
                ev[n] = token_event(KIND_QUOTE, c, 1'b1, 1'b0, pos_line, pos_column, pos_offset);
            end
            else
            begin
                scan_state = SCAN_WORD;
                ev[n] = token_event(KIND_WORD, c, 1'b1, 1'b0, pos_line, pos_column, pos_offset);
            end
            n++;
        end

        pos_offset = (pos_offset == '1) ? pos_offset : pos_offset + 1'b1;
        if (c == CH_NL)
        begin
            pos_line   = (pos_line == '1) ? pos_line : pos_line + 1'b1;
            pos_column = '0;
        end
        else
            pos_column = (pos_column == '1) ? pos_column : pos_column + 1'b1;

        // end of text closes whatever is open, then everything starts afresh
        if (it.end_of_text)
        begin
            if (scan_state != SCAN_IDLE && n > 0)
                ev[n-1].token_final = 1'b1;
            restart_text();
        end
        if (n > 0)
            ev[n-1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_events = {expected_events, ev[i]};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (is_special(c));
        return c;
    endfunction

    function automatic void push_byte(input logic [7:0] c);
        text_buf = {text_buf, in_item_t'{c, 1'b0}};
    endfunction

    // Mostly well-formed texts (words, blanks, marks, quoted strings with escapes)
    // ended by end of text; one in five is raw noise with stray end marks.
    function automatic void build_text();
        int         sel;
        logic [7:0] q;
        text_buf.delete();
        if ($urandom_range(4) == 0)
        begin
            repeat ($urandom_range(20, 4))
                text_buf = {text_buf, in_item_t'{8'($urandom_range(255)),
                                                 1'($urandom_range(29) == 0)}};
            return;
        end
        repeat ($urandom_range(12, 2))
        begin
            case ($urandom_range(9)) inside
                [0:2]:   repeat ($urandom_range(6, 1)) push_byte(plain_char());
                3:       repeat ($urandom_range(3, 1)) push_byte($urandom_range(1) ? CH_SPACE
                                                                             : CH_TAB);
                [4:5]:   push_byte(PUNCT[$urandom_range(PUNCT.len() - 1)]);
                [6:7]:
                begin
                    q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
                    push_byte(q);
                    repeat ($urandom_range(8))
                    begin
                        sel = $urandom_range(11);
                        if (sel < 2)
                        begin
                            push_byte(CH_BSLASH);
                            push_byte(sel == 0 ? q : 8'($urandom_range(255)));
                        end
                        else if (sel == 2)
                            push_byte(CH_NL);
                        else if (sel == 3)
                            push_byte(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
                        else if (sel < 6)
                            push_byte(8'($urandom_range(255)));
                        else
                            push_byte(plain_char());
                    end
                    // now and then the quote is left open for end of text to close
                    if ($urandom_range(9) != 0)
                        push_byte(q);
                end
                8:       push_byte(CH_NL);
                default: push_byte(8'($urandom_range(255)));
            endcase
        end
        text_buf[text_buf.size() - 1].end_of_text = 1'b1;
    endfunction

    // Offers one text transaction, with a random gap first, and predicts its
    // events at the edge where it is taken. Returns at that edge.
    task automatic send_byte(input in_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        text_item  <= it;
        text_valid <= 1'b1;
        do
            @(posedge clk);
        while (!text_ready);
        bytes_sent++;
        lex_byte(it);
    endtask

    task automatic random_texts(input int upto);
        while (bytes_sent < upto)
        begin
            build_text();
            foreach (text_buf[i])
                send_byte(text_buf[i]);
            texts_sent++;
        end
    endtask

    // Drops valid and waits, edge by edge, until the result queue drains
    task automatic drain_results();
        text_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_events.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : token_monitor
        out_item_t want;
        if (rst_n && token_valid && token_ready)
        begin
            events_seen++;
            if (expected_events.size() == 0)
            begin
                $error("token_item: event with nothing expected, kind %0d char 0x%02h",
                       token_item.event_kind, token_item.char_out);
                mismatches++;
            end
            else
            begin
                want = expected_events.pop_front();
                check_field("event_kind", want.event_kind, token_item.event_kind);
                check_field("char_out", want.char_out, token_item.char_out);
                check_field("token_first", want.token_first, token_item.token_first);
                check_field("token_final", want.token_final, token_item.token_final);
                check_field("start_line", want.start_line, token_item.start_line);
                check_field("start_column", want.start_column, token_item.start_column);
                check_field("start_offset", want.start_offset, token_item.start_offset);
                check_field("run_last", want.run_last, token_item.run_last);
            end
        end
        token_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any transaction on either side restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_valid && text_ready) || (token_valid && token_ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("timeout: %0d cycles with no transaction, %0d events outstanding",
                         STALL_LIMIT, expected_events.size());
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        restart_text();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // phase 1: bursty sender, receiver mostly stalled
        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].item);
            if (directed_rows[i].typed)
                expected_events[expected_events.size() - 1] = directed_rows[i].want;
        end
        // hold the sender off until every outstanding event has drained
        drain_results();
        random_texts(150);

        // phase 2: sender mostly idle, receiver occasionally stalled
        send_idle_pct = 88;
        recv_idle_pct = 26;
        random_texts(300);

        // phase 3: no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_texts(450);

        drain_results();
        // time for the input and result registers to empty; any extra event is caught
        repeat (8) @(posedge clk);

        $display("run covered the directed table and %0d random texts, %0d bytes in all,",
                 texts_sent, bytes_sent);
        $display("under three stall patterns; %0d token events checked, %0d mismatches",
                 events_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
